>>> hw/rtl/dc_link_harmonic_observer_unit_macros.svh
// Assertion macros for the DC-link harmonic observer.
// Used by dc_link_harmonic_observer_unit; expects clk_i and rst_ni in scope.
`ifndef DC_LINK_HARMONIC_OBSERVER_UNIT_MACROS_SVH
`define DC_LINK_HARMONIC_OBSERVER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define DCLHO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DCLHO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dclho_pkg.sv
// Package for the DC-link harmonic observer: register codes, fixed-point
// constants and the elaboration-time sine generator. No dependencies.
`default_nettype none

package dclho_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DC_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DC = 2'd2;

  // reset values
  localparam logic [15:0]        ERROR_GAIN_RST = 16'd5792;     // 1.414 in Q4.12
  localparam logic [15:0]        DC_GAIN_RST    = 16'd1600;     // 100 in Q12.4
  localparam logic signed [31:0] INITIAL_DC_RST = 32'sd10485760; // 160 in Q16.16

  // sample period 2e-5 s in Q40, injection gains 377*TS (x2) in Q32
  localparam logic [32:0] TS_Q40   = 33'd21990233;
  localparam logic [32:0] INJ1_Q32 = 33'd32384053;
  localparam logic [32:0] INJ2_Q32 = 33'd64768107;

  localparam logic [63:0] HALFPI_Q30  = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] QUARTER_Q32 = 64'h0000_0000_4000_0000;

  // Taylor denominators (n-1)*n for n = 3, 5, ..., 13
  localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // Q2.30 sine of a 32-bit turn fraction; used only to build the constant table
  function automatic logic signed [31:0] sine_q30(input logic [31:0] ang);
    logic [1:0]        quad;
    logic [63:0]       r;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic [63:0]       pos;
    logic [63:0]       neg;
    logic signed [63:0] s;
    quad = ang[31:30];
    r    = {34'd0, ang[29:0]};
    if (quad[0]) begin
      r = QUARTER_Q32 - r;
    end
    x    = (r * HALFPI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = '0;
    for (int k = 0; k < 6; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if (k % 2 == 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    s = $signed(pos) - $signed(neg);
    if (s < 0) begin
      s = '0;
    end
    if (s > $signed(ONE_Q30)) begin
      s = $signed(ONE_Q30);
    end
    if (quad[1]) begin
      s = -s;
    end
    return s[31:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dc_link_harmonic_observer_unit.sv
// DC-link harmonic observer: DC term plus resonators at f and 2f, one shared
// multiplier under a sequencer. Depends on dclho_pkg and the assertion macros.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word: a Q16.16 DC-link
//   sample and the grid frequency in Q8.8 Hz. Output channel (out_valid_o /
//   out_stall_i) returns one Q16.16 DC estimate per input word.
//   A new word is taken only while the sequencer is idle. The pace is set by
//   the single 34x33 multiplier, which runs every product in turn (phase,
//   error, two DC gain terms, four sin/cos lookups of two products each, eight
//   rotation and two injection terms), and by the one read port of the sine
//   table, which gives one entry per cycle.
//   The estimate sits in an output register, so the next word is accepted while
//   the previous result is still stalled. If the receiver still holds the
//   register when a new estimate is ready, the sequencer waits in its last step.
//   Reset clears both resonators, loads the DC term with 160 V and restores the
//   default gains. Writing initial_dc also presets the DC term. Configuration
//   must be written only while the block is idle; the block does not check it.
`default_nettype none

`include "dc_link_harmonic_observer_unit_macros.svh"

module dc_link_harmonic_observer_unit #(
  parameter int unsigned SINCOS_TABLE_DEPTH = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [dclho_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [31:0]                         cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [31:0]                  vdc_sample_i,
  input  wire logic [15:0]                         grid_frequency_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [31:0]                       dc_estimate_o
);

  localparam int unsigned IW = $clog2(SINCOS_TABLE_DEPTH);

  // sequencer codes
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_PH   = 5'd1;
  localparam logic [4:0] ST_ERR  = 5'd2;
  localparam logic [4:0] ST_G    = 5'd3;
  localparam logic [4:0] ST_DC   = 5'd4;
  localparam logic [4:0] ST_DCN  = 5'd5;
  localparam logic [4:0] ST_POS  = 5'd6;
  localparam logic [4:0] ST_ADR0 = 5'd7;
  localparam logic [4:0] ST_ADR1 = 5'd8;
  localparam logic [4:0] ST_INT  = 5'd9;
  localparam logic [4:0] ST_SUM  = 5'd10;
  localparam logic [4:0] ST_CX   = 5'd11;
  localparam logic [4:0] ST_SQ   = 5'd12;
  localparam logic [4:0] ST_INJ  = 5'd13;
  localparam logic [4:0] ST_SX   = 5'd14;
  localparam logic [4:0] ST_CQ   = 5'd15;
  localparam logic [4:0] ST_NQ   = 5'd16;
  localparam logic [4:0] ST_OUT  = 5'd17;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // constant sine table, Q2.30, registered read
  logic signed [31:0] sine_rom [SINCOS_TABLE_DEPTH];
  for (genvar gi = 0; gi < SINCOS_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [31:0] ANGLE = 32'((64'(gi) << 32) / SINCOS_TABLE_DEPTH);
    assign sine_rom[gi] = dclho_pkg::sine_q30(ANGLE);
  end

  // control state
  logic [4:0]         state_q, state_d;
  logic [1:0]         sel_q, sel_d;       // [1] second harmonic, [0] cosine pass
  logic               out_valid_q, out_valid_d;
  logic [15:0]        eg_q, eg_d;
  logic [15:0]        dg_q, dg_d;
  logic signed [31:0] fi_q, fi_d;
  logic signed [31:0] fq_q, fq_d;
  logic signed [31:0] si_q, si_d;
  logic signed [31:0] sq_q, sq_d;
  logic signed [31:0] dc_q, dc_d;

  // datapath
  logic signed [31:0] vdc_q, vdc_d;
  logic [15:0]        f_q, f_d;
  logic [31:0]        ph1_q, ph1_d;
  logic [31:0]        ph2_q, ph2_d;
  logic signed [31:0] err_q, err_d;
  logic signed [31:0] dcn_q, dcn_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [29:0]        frac_q, frac_d;
  logic signed [31:0] s0_q, s0_d;
  logic signed [31:0] sin_q, sin_d;
  logic signed [31:0] cos_q, cos_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [31:0] nx_q, nx_d;
  logic signed [31:0] out_q, out_d;
  logic signed [31:0] rom_q;
  logic [IW-1:0]      rom_addr;

  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] prod_q;
  logic signed [66:0] prod_d;
  logic signed [63:0] prod64;

  logic signed [33:0] diff;
  logic signed [31:0] x_s, q_s;
  logic [31:0]        ph_s, angle;
  logic signed [31:0] nq;

  assign prod_d = mul_a * mul_b;
  assign prod64 = prod_q[63:0];

  assign diff  = 34'(vdc_q) - 34'(fi_q) - 34'(si_q) - 34'(dc_q);
  assign x_s   = sel_q[1] ? si_q : fi_q;
  assign q_s   = sel_q[1] ? sq_q : fq_q;
  assign ph_s  = sel_q[1] ? ph2_q : ph1_q;
  assign angle = sel_q[0] ? ph_s + 32'h4000_0000 : ph_s;
  assign nq    = sat32((acc_q + prod64) >>> 30);

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign dc_estimate_o = out_q;

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q & out_stall_i;
    eg_d        = eg_q;
    dg_d        = dg_q;
    fi_d        = fi_q;
    fq_d        = fq_q;
    si_d        = si_q;
    sq_d        = sq_q;
    dc_d        = dc_q;
    vdc_d       = vdc_q;
    f_d         = f_q;
    ph1_d       = ph1_q;
    ph2_d       = ph2_q;
    err_d       = err_q;
    dcn_d       = dcn_q;
    idx_d       = idx_q;
    frac_d      = frac_q;
    s0_d        = s0_q;
    sin_d       = sin_q;
    cos_d       = cos_q;
    acc_d       = acc_q;
    nx_d        = nx_q;
    out_d       = out_q;
    rom_addr    = idx_q;
    mul_a       = '0;
    mul_b       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          vdc_d   = vdc_sample_i;
          f_d     = grid_frequency_i;
          state_d = ST_PH;
        end
      end
      ST_PH: begin
        mul_a   = $signed({18'd0, f_q});
        mul_b   = $signed(dclho_pkg::TS_Q40);
        state_d = ST_ERR;
      end
      ST_ERR: begin
        ph1_d   = prod_q[47:16];
        ph2_d   = prod_q[46:15];  // twice the frequency
        mul_a   = diff;
        mul_b   = $signed({17'd0, eg_q});
        state_d = ST_G;
      end
      ST_G: begin
        err_d   = sat32(prod64 >>> 12);
        mul_a   = $signed({18'd0, dg_q});
        mul_b   = $signed(dclho_pkg::TS_Q40);
        state_d = ST_DC;
      end
      ST_DC: begin
        // DC gain in Q32 straight from the product register
        mul_a   = 34'(err_q);
        mul_b   = $signed({4'd0, prod_q[40:12]});
        state_d = ST_DCN;
      end
      ST_DCN: begin
        dcn_d   = sat32(64'(dc_q) + (prod64 >>> 32));
        sel_d   = 2'd0;
        state_d = ST_POS;
      end
      ST_POS: begin
        mul_a   = $signed({2'd0, angle});
        mul_b   = $signed(33'(SINCOS_TABLE_DEPTH));
        state_d = ST_ADR0;
      end
      ST_ADR0: begin
        idx_d    = prod_q[32 +: IW];
        frac_d   = prod_q[31:2];
        rom_addr = prod_q[32 +: IW];
        state_d  = ST_ADR1;
      end
      ST_ADR1: begin
        s0_d     = rom_q;
        rom_addr = (idx_q == IW'(SINCOS_TABLE_DEPTH - 1)) ? '0 : idx_q + IW'(1);
        state_d  = ST_INT;
      end
      ST_INT: begin
        mul_a   = 34'(rom_q) - 34'(s0_q);
        mul_b   = $signed({3'd0, frac_q});
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (sel_q[0]) begin
          cos_d   = s0_q + $signed(prod_q[61:30]);
          state_d = ST_CX;
        end else begin
          sin_d   = s0_q + $signed(prod_q[61:30]);
          sel_d   = sel_q + 2'd1;
          state_d = ST_POS;
        end
      end
      ST_CX: begin
        mul_a   = 34'(cos_q);
        mul_b   = 33'(x_s);
        state_d = ST_SQ;
      end
      ST_SQ: begin
        acc_d   = prod64;
        mul_a   = 34'(sin_q);
        mul_b   = 33'(q_s);
        state_d = ST_INJ;
      end
      ST_INJ: begin
        acc_d   = acc_q - prod64;
        mul_a   = 34'(err_q);
        mul_b   = sel_q[1] ? $signed(dclho_pkg::INJ2_Q32) : $signed(dclho_pkg::INJ1_Q32);
        state_d = ST_SX;
      end
      ST_SX: begin
        nx_d    = sat32((acc_q >>> 30) + (prod64 >>> 32));
        mul_a   = 34'(sin_q);
        mul_b   = 33'(x_s);
        state_d = ST_CQ;
      end
      ST_CQ: begin
        acc_d   = prod64;
        mul_a   = 34'(cos_q);
        mul_b   = 33'(q_s);
        state_d = ST_NQ;
      end
      ST_NQ: begin
        if (sel_q[1]) begin
          si_d    = nx_q;
          sq_d    = nq;
          dc_d    = dcn_q;
          state_d = ST_OUT;
        end else begin
          fi_d    = nx_q;
          fq_d    = nq;
          sel_d   = 2'd2;
          state_d = ST_POS;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = dc_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        dclho_pkg::REG_ERROR_GAIN: eg_d = cfg_data_i[15:0];
        dclho_pkg::REG_DC_GAIN:    dg_d = cfg_data_i[15:0];
        dclho_pkg::REG_INITIAL_DC: dc_d = $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= '0;
      out_valid_q <= 1'b0;
      eg_q        <= dclho_pkg::ERROR_GAIN_RST;
      dg_q        <= dclho_pkg::DC_GAIN_RST;
      fi_q        <= '0;
      fq_q        <= '0;
      si_q        <= '0;
      sq_q        <= '0;
      dc_q        <= dclho_pkg::INITIAL_DC_RST;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
      eg_q        <= eg_d;
      dg_q        <= dg_d;
      fi_q        <= fi_d;
      fq_q        <= fq_d;
      si_q        <= si_d;
      sq_q        <= sq_d;
      dc_q        <= dc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rom_q  <= sine_rom[rom_addr];
    vdc_q  <= vdc_d;
    f_q    <= f_d;
    ph1_q  <= ph1_d;
    ph2_q  <= ph2_d;
    err_q  <= err_d;
    dcn_q  <= dcn_d;
    idx_q  <= idx_d;
    frac_q <= frac_d;
    s0_q   <= s0_d;
    sin_q  <= sin_d;
    cos_q  <= cos_d;
    acc_q  <= acc_d;
    nx_q   <= nx_d;
    out_q  <= out_d;
  end

  `DCLHO_ASSERT_NEXT(a_accept_starts, in_valid_i && !in_stall_o, state_q == ST_PH, "accepted word did not start the sequence")
  `DCLHO_ASSERT_NOW(a_out_from_last_step, $rose(out_valid_q), $past(state_q) == ST_OUT, "result raised outside the output step")
  `DCLHO_ASSERT_NOW(a_dc_update_src, dc_q != $past(dc_q), ($past(state_q) == ST_NQ && $past(sel_q[1])) || ($past(cfg_we_i) && $past(cfg_index_i) == dclho_pkg::REG_INITIAL_DC), "DC term changed outside its update")
  `DCLHO_ASSERT_NOW(a_rotate_after_cos, state_q == ST_CX, sel_q[0], "rotation started before the cosine pass")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for dc_link_harmonic_observer_unit: a directed table, then random
// ripple streams under several gain settings, checked against a bit-exact observer.
// Depends on dclho_pkg and the observer RTL.
module tb_top;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned LUT_IW = $clog2(TABLE_DEPTH);
  localparam longint unsigned SAMPLE_PERIOD_Q40 = 64'd21990233;
  localparam longint FUND_INJ_Q32 = 64'sd32384053;
  localparam longint SECOND_INJ_Q32 = 64'sd64768107;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint UNITY_Q30 = 64'sd1073741824;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [dclho_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index
  localparam logic [15:0] DEF_ERROR_GAIN = 16'd5792;
  localparam logic [15:0] DEF_DC_GAIN = 16'd1600;
  localparam logic signed [31:0] DEF_INITIAL_DC = 32'sd10485760;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam int DRAIN_CYCLES = 45;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 225;
  localparam int N_DIRECTED = 25;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                           kind;
    logic [dclho_pkg::CFG_IDX_W-1:0]     index;
    logic [31:0]                         data;
    logic signed [31:0]                  vdc;
    logic [15:0]                         freq;
    logic                                has_exp;
    logic signed [31:0]                  exp_dc;
  } stim_row_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic [dclho_pkg::CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [31:0]                         cfg_data_i = '0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic signed [31:0]                  vdc_sample_i = '0;
  logic [15:0]                         grid_frequency_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [31:0]                  dc_estimate_o;

  // typed-in expectation travels with the word like a sideband
  logic                  row_has_exp = 1'b0;
  logic signed [31:0]    row_exp_dc = '0;

  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  logic                  hold_off_req = 1'b0;
  int                    hold_off_left = 0;
  int                    mismatch_count = 0;

  // observer model state
  logic signed [31:0]    sine_lut [TABLE_DEPTH];
  logic [15:0]           gain_k;
  logic [15:0]           gain_dc;
  longint                fund_x, fund_q, second_x, second_q, dc_acc;
  logic signed [31:0]    expected_dc_q [$];
  logic signed [31:0]    predicted_dc;
  logic signed [31:0]    want_dc;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // defaults with the sample equal to the preset: zero error, DC holds
    '{ROW_SAMPLE, '0, 32'h0, 32'sd10485760, 16'd12800, 1'b1, 32'sd10485760},
    '{ROW_WRITE, dclho_pkg::REG_ERROR_GAIN, 32'h0, 32'sh0, 16'h0, 1'b0, 32'sh0},
    '{ROW_SAMPLE, '0, 32'h0, S32_MAX, 16'hFFFF, 1'b1, 32'sd10485760},
    '{ROW_SAMPLE, '0, 32'h0, S32_MIN, 16'h0000, 1'b1, 32'sd10485760},
    '{ROW_WRITE, dclho_pkg::REG_INITIAL_DC, 32'hFFFB_0000, 32'sh0, 16'h0, 1'b0, 32'sh0},
    '{ROW_SAMPLE, '0, 32'h0, 32'sh0, 16'd15360, 1'b1, 32'shFFFB_0000},
    '{ROW_WRITE, REG_SPARE, 32'h1234_5678, 32'sh0, 16'h0, 1'b0, 32'sh0},
    '{ROW_SAMPLE, '0, 32'h0, -32'sd1, 16'hFFFF, 1'b1, 32'shFFFB_0000},
    '{ROW_WRITE, dclho_pkg::REG_ERROR_GAIN, 32'h0000_FFFF, 32'sh0, 16'h0, 1'b0, 32'sh0},
    '{ROW_WRITE, dclho_pkg::REG_DC_GAIN, 32'h0000_FFFF, 32'sh0, 16'h0, 1'b0, 32'sh0},
    '{ROW_WRITE, dclho_pkg::REG_INITIAL_DC, 32'h7FFF_0000, 32'sh0, 16'h0, 1'b0, 32'sh0},
    '{ROW_SAMPLE, '0, 32'h0, S32_MAX, 16'd12800, 1'b1, S32_MAX},
    '{ROW_WRITE, dclho_pkg::REG_INITIAL_DC, 32'h8001_0000, 32'sh0, 16'h0, 1'b0, 32'sh0},
    '{ROW_SAMPLE, '0, 32'h0, S32_MIN, 16'd12800, 1'b1, S32_MIN},
    '{ROW_WRITE, dclho_pkg::REG_DC_GAIN, 32'h0, 32'sh0, 16'h0, 1'b0, 32'sh0},
    '{ROW_WRITE, dclho_pkg::REG_INITIAL_DC, 32'h0064_0000, 32'sh0, 16'h0, 1'b0, 32'sh0},
    '{ROW_SAMPLE, '0, 32'h0, 32'sh0190_0000, 16'd15360, 1'b1, 32'sh0064_0000},
    '{ROW_SAMPLE, '0, 32'h0, 32'sh0, 16'hFFFF, 1'b1, 32'sh0064_0000},
    '{ROW_WRITE, dclho_pkg::REG_DC_GAIN, 32'd1600, 32'sh0, 16'h0, 1'b0, 32'sh0},
    '{ROW_WRITE, dclho_pkg::REG_ERROR_GAIN, 32'd5792, 32'sh0, 16'h0, 1'b0, 32'sh0},
    '{ROW_SAMPLE, '0, 32'h0, 32'sh00A0_0000, 16'd15360, 1'b0, 32'sh0},
    '{ROW_SAMPLE, '0, 32'h0, 32'sh00A8_0000, 16'd15360, 1'b0, 32'sh0},
    '{ROW_SAMPLE, '0, 32'h0, S32_MAX, 16'h0000, 1'b0, 32'sh0},
    '{ROW_SAMPLE, '0, 32'h0, S32_MIN, 16'hFFFF, 1'b0, 32'sh0},
    '{ROW_SAMPLE, '0, 32'h0, 32'sh0, 16'h0001, 1'b0, 32'sh0}
  };

  dc_link_harmonic_observer_unit #(
    .SINCOS_TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .vdc_sample_i     (vdc_sample_i),
    .grid_frequency_i (grid_frequency_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .dc_estimate_o    (dc_estimate_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic logic signed [31:0] taylor_sine(input logic [31:0] ang);
    logic [1:0]      quad;
    longint unsigned r, x, x2, term, pos, neg, div;
    longint          s;
    int              n;
    quad = ang[31:30];
    r = 64'(ang[29:0]);
    if (quad[0]) begin
      r = 64'h4000_0000 - r;
    end
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    pos = x;
    neg = 0;
    for (n = 3; n <= 13; n += 2) begin
      div = 64'((n - 1) * n);
      term = ((term * x2) >> 30) / div;
      if (((n - 1) / 2) % 2 == 1) begin
        neg += term;
      end else begin
        pos += term;
      end
    end
    s = longint'(pos) - longint'(neg);
    if (s < 0) begin
      s = 0;
    end
    if (s > UNITY_Q30) begin
      s = UNITY_Q30;
    end
    if (quad[1]) begin
      s = -s;
    end
    return s[31:0];
  endfunction

  // linear interpolation between table entries, Q2.30
  function automatic longint lut_sin(input logic [31:0] phase);
    longint unsigned p, idx, nxt;
    longint          frac, s0, s1;
    p = 64'(phase);
    p = p * TABLE_DEPTH;
    idx = p >> 32;
    nxt = (idx + 1 >= TABLE_DEPTH) ? 0 : idx + 1;
    frac = (p & 64'hFFFF_FFFF) >> 2;
    s0 = longint'(sine_lut[idx[LUT_IW-1:0]]);
    s1 = longint'(sine_lut[nxt[LUT_IW-1:0]]);
    return s0 + (((s1 - s0) * frac) >>> 30);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > longint'(S32_MAX)) begin
      return longint'(S32_MAX);
    end
    if (v < longint'(S32_MIN)) begin
      return longint'(S32_MIN);
    end
    return v;
  endfunction

  function automatic void rotate_resonator(inout longint x, inout longint q,
                                           input logic [31:0] phase,
                                           input longint err, input longint inj);
    logic [31:0] cos_phase;
    longint      s, c, nx;
    cos_phase = phase + QUARTER_TURN;
    s = lut_sin(phase);
    c = lut_sin(cos_phase);
    nx = clamp32(((c * x - s * q) >>> 30) + ((err * inj) >>> 32));
    q = clamp32((s * x + c * q) >>> 30);
    x = nx;
  endfunction

  function automatic logic signed [31:0] observer_step(input logic signed [31:0] vdc,
                                                       input logic [15:0] freq);
    longint unsigned fw, gdc;
    logic [31:0]     ph1, ph2;
    longint          k, diff, err, g, dcn;
    fw = 64'(freq);
    gdc = 64'(gain_dc);
    k = 64'(gain_k);
    ph1 = 32'((fw * SAMPLE_PERIOD_Q40) >> 16);
    ph2 = 32'(((fw << 1) * SAMPLE_PERIOD_Q40) >> 16);
    diff = longint'(vdc) - fund_x - second_x - dc_acc;
    err = clamp32((diff * k) >>> 12);
    g = (gdc * SAMPLE_PERIOD_Q40) >> 12;
    dcn = clamp32(dc_acc + ((err * g) >>> 32));
    rotate_resonator(fund_x, fund_q, ph1, err, FUND_INJ_Q32);
    rotate_resonator(second_x, second_q, ph2, err, SECOND_INJ_Q32);
    dc_acc = dcn;
    return dcn[31:0];
  endfunction

  function automatic void observer_reset();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sine_lut[i] = taylor_sine(32'((64'(i) << 32) / TABLE_DEPTH));
    end
    gain_k = DEF_ERROR_GAIN;
    gain_dc = DEF_DC_GAIN;
    fund_x = 0;
    fund_q = 0;
    second_x = 0;
    second_q = 0;
    dc_acc = longint'(DEF_INITIAL_DC);
  endfunction

  // ----------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    // keep the log short if the block is badly off
    if (mismatch_count < 50) begin
      $display("MISMATCH at %0t: %s: dc_estimate got %0d, want %0d",
               $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted_dc = observer_step(vdc_sample_i, grid_frequency_i);
        expected_dc_q.push_back(row_has_exp ? row_exp_dc : predicted_dc);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_dc_q.size() == 0) begin
          report_mismatch("estimate word with none outstanding", dc_estimate_o, 'x);
        end else begin
          want_dc = expected_dc_q.pop_front();
          if (dc_estimate_o !== want_dc) begin
            report_mismatch("wrong estimate", dc_estimate_o, want_dc);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_left = HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_off_left > 0) begin
      out_stall_i <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------- stimulus

  task automatic send_word(input logic signed [31:0] vdc, input logic [15:0] freq,
                           input logic has_exp, input logic signed [31:0] exp_dc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vdc_sample_i <= vdc;
    grid_frequency_i <= freq;
    row_has_exp <= has_exp;
    row_exp_dc <= exp_dc;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  // drop valid, let every outstanding word come back, then settle
  task automatic wait_drained(input int settle);
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (expected_dc_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [dclho_pkg::CFG_IDX_W-1:0] index,
                           input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      dclho_pkg::REG_ERROR_GAIN: gain_k = data[15:0];
      dclho_pkg::REG_DC_GAIN:    gain_dc = data[15:0];
      dclho_pkg::REG_INITIAL_DC: dc_acc = longint'($signed(data));
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [15:0]        eg, dg, freq, nominal;
    logic signed [31:0] preset, vdc;
    logic [31:0]        ripple_phase, ripple_phase2;
    longint unsigned    step;
    longint             amp1, amp2, noise;

    observer_reset();
    ripple_phase = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_idle_pct = 33;
    recv_idle_pct = 55;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_drained(DRAIN_CYCLES);
        cfg_write(directed_rows[i].index, directed_rows[i].data);
      end else begin
        send_word(directed_rows[i].vdc, directed_rows[i].freq,
                  directed_rows[i].has_exp, directed_rows[i].exp_dc);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          eg = DEF_ERROR_GAIN;
          dg = DEF_DC_GAIN;
          preset = DEF_INITIAL_DC;
        end
        1: begin
          eg = 16'hFFFF;
          dg = 16'hFFFF;
          preset = S32_MAX;
        end
        2: begin
          eg = 16'($urandom);
          dg = 16'h0000;
          preset = S32_MIN;
        end
        default: begin
          eg = 16'($urandom_range(0, 16383));
          dg = 16'($urandom);
          preset = $urandom_range(0, 800) << 16;
        end
      endcase
      wait_drained(DRAIN_CYCLES);
      cfg_write(dclho_pkg::REG_ERROR_GAIN, {16'($urandom), eg});
      cfg_write(dclho_pkg::REG_DC_GAIN, {16'($urandom), dg});
      cfg_write(dclho_pkg::REG_INITIAL_DC, preset);
      send_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 55 : 0;
      recv_idle_pct = (ph < 2) ? 55 : (ph < 4) ? 33 : 0;
      nominal = ($urandom_range(1)) ? 16'd12800 : 16'd15360;
      amp1 = 64'($urandom_range(0, 20 * 65536));
      amp2 = 64'($urandom_range(0, 8 * 65536));

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (ph == 1 && n == 60) begin
          hold_off_req = 1'b1;
        end
        if ($urandom_range(99) < 80) begin
          // ripple at f and 2f on top of the preset level
          freq = 16'(nominal + $urandom_range(0, 512) - 256);
          step = 64'(freq);
          step = (step * SAMPLE_PERIOD_Q40) >> 16;
          ripple_phase = ripple_phase + step[31:0];
          ripple_phase2 = ripple_phase << 1;
          noise = 64'($urandom_range(0, 131072));
          noise = noise - 65536;
          vdc = 32'(clamp32(longint'(preset) + ((amp1 * lut_sin(ripple_phase)) >>> 30)
                            + ((amp2 * lut_sin(ripple_phase2)) >>> 30) + noise));
        end else begin
          vdc = $urandom;
          freq = 16'($urandom);
        end
        send_word(vdc, freq, 1'b0, '0);
      end
    end

    wait_drained(DRAIN_CYCLES);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
